// ===== rtl/cke_pkg.sv =====
// ----------------------------------------------------------------------------
// cke_pkg: shared types and constants of the canonical k-mer encoder
// Request structs, per-cell control, decode constants and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cke_pkg;

	localparam int CODE_W  = 62;
	localparam int K_W     = 5;
	localparam int FILL_W  = 6;
	localparam int CFG_W   = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CELLS_MAX = CODE_W / 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_K_LEN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_N = 1'd1;

	// ASCII characters
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// 2-bit base codes; the complement flips the low bit
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_T = 2'd1;
	localparam logic [1:0] BASE_C = 2'd2;
	localparam logic [1:0] BASE_G = 2'd3;
	localparam logic [1:0] COMP_MASK = 2'd1;

	localparam logic [FILL_W-1:0] FILL_SAT = {FILL_W{1'b1}};

	typedef struct packed {
		logic [7:0] base_char;
		logic       seq_start;
	} cke_in_t;

	typedef struct packed {
		logic              kmer_valid;
		logic [CODE_W-1:0] fwd_code;
		logic [CODE_W-1:0] rev_code;
		logic [CODE_W-1:0] canonical_code;
		logic              edge_valid;
		logic [CODE_W-1:0] edge_from_fwd;
		logic [3:0]        edge_fwd_hot;
		logic [3:0]        edge_rev_hot;
		logic              bad_char;
	} cke_out_t;

	// control broadcast to every cell of the window
	typedef struct packed {
		logic           load;
		logic           wipe;
		logic           clr_first;
		logic [1:0]     code;
		logic [K_W-1:0] k;
	} cke_cell_ctl_t;

	// per-request status from the controller
	typedef struct packed {
		logic       bad;
		logic       kmer_ok;
		logic       edge_ok;
		logic [1:0] code;
	} cke_stat_t;

endpackage

`default_nettype wire

// ===== rtl/cke_cell.sv =====
// ----------------------------------------------------------------------------
// cke_cell: one base position of the rolling window
// Holds one forward and one reverse-complement digit and shifts them on load.
// ----------------------------------------------------------------------------
`default_nettype none

module cke_cell #(
	parameter int IDX = 0
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire cke_pkg::cke_cell_ctl_t ctl,
	input  wire  [1:0]                  fwd_in,
	input  wire  [1:0]                  rev_in,
	output logic [1:0]                  fwd_digit,
	output logic [1:0]                  rev_digit,
	output logic [1:0]                  fwd_next,
	output logic [1:0]                  rev_next,
	output logic [1:0]                  fwd_old,
	output logic [1:0]                  drop
);

	logic [1:0] fwd_q;
	logic [1:0] rev_q;
	logic       in_win;
	logic       is_top;
	logic       keep_lower;

	assign in_win     = ctl.k > cke_pkg::K_W'(IDX);
	assign is_top     = ctl.k == cke_pkg::K_W'(IDX + 1);
	// the first cell always takes the new base; others drop history on a new sequence
	assign keep_lower = (IDX == 0) || !ctl.clr_first;

	always_comb begin
		fwd_next = 2'd0;
		rev_next = 2'd0;
		if (in_win) begin
			fwd_next = keep_lower ? fwd_in : 2'd0;
			if (is_top) begin
				rev_next = ctl.code ^ cke_pkg::COMP_MASK;
			end else begin
				rev_next = ctl.clr_first ? 2'd0 : rev_in;
			end
		end
	end

	assign fwd_old   = in_win ? fwd_q : 2'd0;
	assign drop      = is_top ? fwd_q : 2'd0;
	assign fwd_digit = fwd_q;
	assign rev_digit = rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 2'd0;
			rev_q <= 2'd0;
		end else if (ctl.load) begin
			fwd_q <= fwd_next;
			rev_q <= rev_next;
		end else if (ctl.wipe) begin
			fwd_q <= 2'd0;
			rev_q <= 2'd0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cke_ctrl.sv =====
// ----------------------------------------------------------------------------
// cke_ctrl: configuration, character decode and fill tracking
// Drives the cell control and reports validity of the k-mer and the edge.
// ----------------------------------------------------------------------------
`default_nettype none

module cke_ctrl #(
	parameter int MAX_K = 31
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [cke_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [cke_pkg::CFG_W-1:0]           cfg_data,
	input  wire                                 accept,
	input  wire cke_pkg::cke_in_t               item,
	output cke_pkg::cke_cell_ctl_t              ctl,
	output cke_pkg::cke_stat_t                  stat
);

	localparam logic [cke_pkg::K_W-1:0] KMAX = cke_pkg::K_W'(MAX_K);

	logic [cke_pkg::K_W-1:0]    k_len_q;
	logic                       skip_n_q;
	logic [cke_pkg::FILL_W-1:0] fill_q;
	logic [cke_pkg::FILL_W-1:0] fill_base;
	logic [cke_pkg::FILL_W-1:0] fill_new;
	logic [cke_pkg::K_W-1:0]    k_eff;
	logic [7:0]                 ch;
	logic                       is_base;
	logic [1:0]                 code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_len_q  <= cke_pkg::K_W'(31);
			skip_n_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				cke_pkg::REG_K_LEN:  k_len_q  <= cfg_data;
				cke_pkg::REG_SKIP_N: skip_n_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		k_eff = k_len_q;
		if (k_len_q == '0) begin
			k_eff = cke_pkg::K_W'(1);
		end else if (k_len_q > KMAX) begin
			k_eff = KMAX;
		end
	end

	// fold lower case, then decode
	always_comb begin
		ch = item.base_char;
		if (ch inside {[cke_pkg::CH_LOW_A:cke_pkg::CH_LOW_Z]}) begin
			ch = ch - cke_pkg::CASE_OFS;
		end
		is_base = 1'b1;
		case (ch)
			cke_pkg::CH_A: code = cke_pkg::BASE_A;
			cke_pkg::CH_T: code = cke_pkg::BASE_T;
			cke_pkg::CH_C: code = cke_pkg::BASE_C;
			cke_pkg::CH_G: code = cke_pkg::BASE_G;
			default: begin
				code    = cke_pkg::BASE_A;
				is_base = 1'b0;
			end
		endcase
	end

	assign fill_base = item.seq_start ? '0 : fill_q;
	assign fill_new  = (fill_base == cke_pkg::FILL_SAT) ? fill_base : fill_base + 1'b1;

	always_comb begin
		stat.bad     = !is_base && !((ch == cke_pkg::CH_N) && skip_n_q);
		stat.kmer_ok = is_base && (fill_new >= {1'b0, k_eff});
		stat.edge_ok = stat.kmer_ok && (fill_base >= {1'b0, k_eff});
		stat.code    = code;
	end

	always_comb begin
		ctl.load      = accept && is_base;
		ctl.wipe      = accept && !is_base;
		ctl.clr_first = item.seq_start;
		ctl.code      = code;
		ctl.k         = k_eff;
	end

	// advance the fill count on bases, drop it on anything else
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= is_base ? fill_new : '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/canonical_kmer_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_stream_encoder: rolling canonical k-mer and edge encoder
// A row of base cells holds the forward and reverse-complement windows.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries one ASCII character per
//   request plus seq_start, which clears the window before that character.
//   result channel (result_valid/result_ready/result) returns exactly one
//   result per request: codes, de Bruijn edge one-hots and bad_char.
//   cfg_we/cfg_index/cfg_data write the window length k and skip_n; write
//   them only while no request is in flight.
// The result is registered: a request shows its result in the cycle after it
// is accepted. Throughput is one request per cycle unless the receiver stalls;
// each cell shifts its digit to its neighbor as a base is taken; nothing iterates.
// The result sits in a single output register; item_ready stays high while
// that register is empty or is being taken, so a stalled receiver holds the
// result and backs up the item side after one request.
// Reset clears the windows and fill count, sets k to 31 and skip_n to 1;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_kmer_stream_encoder #(
	parameter int MAX_K = 31
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [cke_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [cke_pkg::CFG_W-1:0]        cfg_data,
	input  wire                              item_valid,
	output logic                             item_ready,
	input  wire cke_pkg::cke_in_t            item,
	output logic                             result_valid,
	input  wire                              result_ready,
	output cke_pkg::cke_out_t                result
);

	localparam int CW = cke_pkg::CODE_W;

	logic                   accept;
	cke_pkg::cke_cell_ctl_t ctl;
	cke_pkg::cke_stat_t     stat;

	logic [1:0] fwd_digit [MAX_K];
	logic [1:0] rev_digit [MAX_K];
	logic [1:0] drop_part [MAX_K];

	logic [CW-1:0] f_vec;
	logic [CW-1:0] r_vec;
	logic [CW-1:0] old_vec;
	logic [1:0]    dropped;

	cke_pkg::cke_out_t res_d;
	cke_pkg::cke_out_t res_q;
	logic              res_valid_q;

	assign item_ready = !res_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	cke_ctrl #(
		.MAX_K(MAX_K)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.item     (item),
		.ctl      (ctl),
		.stat     (stat)
	);

	// the row of cells: forward digits move up, reverse digits move down
	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		logic [1:0] fwd_in;
		logic [1:0] rev_in;

		if (i == 0) begin : g_first
			assign fwd_in = ctl.code;
		end else begin : g_mid
			assign fwd_in = fwd_digit[i-1];
		end

		if (i == MAX_K - 1) begin : g_last
			assign rev_in = 2'd0;
		end else begin : g_inner
			assign rev_in = rev_digit[i+1];
		end

		cke_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.fwd_in   (fwd_in),
			.rev_in   (rev_in),
			.fwd_digit(fwd_digit[i]),
			.rev_digit(rev_digit[i]),
			.fwd_next (f_vec[2*i +: 2]),
			.rev_next (r_vec[2*i +: 2]),
			.fwd_old  (old_vec[2*i +: 2]),
			.drop     (drop_part[i])
		);
	end

	// positions beyond the largest window read as zero
	for (genvar j = MAX_K; j < cke_pkg::CELLS_MAX; j++) begin : g_pad
		assign f_vec[2*j +: 2]   = 2'd0;
		assign r_vec[2*j +: 2]   = 2'd0;
		assign old_vec[2*j +: 2] = 2'd0;
	end

	// only the top cell of the window contributes the dropped base
	always_comb begin
		dropped = 2'd0;
		for (int n = 0; n < MAX_K; n++) begin
			dropped = dropped | drop_part[n];
		end
	end

	// build the result; fields that do not apply stay zero
	always_comb begin
		res_d = '0;
		res_d.bad_char = stat.bad;
		if (stat.kmer_ok) begin
			res_d.kmer_valid     = 1'b1;
			res_d.fwd_code       = f_vec;
			res_d.rev_code       = r_vec;
			res_d.canonical_code = (f_vec < r_vec) ? f_vec : r_vec;
		end
		if (stat.edge_ok) begin
			res_d.edge_valid    = 1'b1;
			res_d.edge_from_fwd = old_vec;
			res_d.edge_fwd_hot  = 4'(1) << stat.code;
			res_d.edge_rev_hot  = 4'(1) << (dropped ^ cke_pkg::COMP_MASK);
		end
	end

	// output register: load on accept, hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTH
	a_edge_needs_kmer: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.edge_valid |-> result.kmer_valid)
		else $error("edge reported without a valid k-mer");

	a_bad_no_kmer: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_char |-> !result.kmer_valid)
		else $error("bad character reported with a valid k-mer");

	a_edge_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.edge_valid |->
			$onehot(result.edge_fwd_hot) && $onehot(result.edge_rev_hot))
		else $error("edge nibbles are not one-hot");

	a_canon_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kmer_valid |->
			result.canonical_code <= result.fwd_code &&
			result.canonical_code <= result.rev_code)
		else $error("canonical code is not the smaller strand");

	a_start_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.seq_start |=> !result.edge_valid)
		else $error("edge reported on the first base of a sequence");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for canonical_kmer_stream_encoder
// Streams characters through the item channel and predicts the rolling
// forward, reverse-complement and canonical codes and the edge one-hots of
// every request. Each result is checked field by field against the oldest
// prediction. Directed cases and a full-window run come first, then random
// phases over several k and skip settings with random idling on both channels.
// ----------------------------------------------------------------------------

module tb;

	localparam int HANG_LIMIT = 2000;
	localparam int PHASES     = 8;
	localparam int PHASE_REQS = 160;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [cke_pkg::CFG_IDX_W-1:0] cfg_index = cke_pkg::REG_K_LEN;
	logic [cke_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          item_valid = 1'b0;
	logic                          item_ready;
	cke_pkg::cke_in_t              req_item = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	cke_pkg::cke_out_t             result;

	// predictor state and its copy of the registers
	logic [cke_pkg::CODE_W-1:0] fwd_win;
	logic [cke_pkg::CODE_W-1:0] rev_win;
	logic [cke_pkg::FILL_W-1:0] fill_cnt;
	logic [cke_pkg::K_W-1:0]    k_len;
	logic                       skip_on;

	cke_pkg::cke_out_t pending_kmers[$];

	// run controls shared by the driver processes
	bit calm = 1'b0;
	int gap_pct = 20;
	int stall_pct = 20;
	int quiet_cycles = 0;

	int n_chars = 0;
	int n_results = 0;
	int n_kmers = 0;
	int n_edges = 0;
	int n_bad = 0;
	int n_settings = 0;
	int mismatches = 0;

	canonical_kmer_stream_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (req_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Predictor
	// --------------------------------------------------------------------
	function automatic void clear_window();
		fwd_win = '0;
		rev_win = '0;
		fill_cnt = '0;
	endfunction

	// Shift one character into the windows and return the result it causes.
	function automatic cke_pkg::cke_out_t encode_base(input cke_pkg::cke_in_t req);
		cke_pkg::cke_out_t o;
		logic [7:0]  ch;
		int unsigned k;
		int unsigned top;
		logic [63:0] mask;
		logic [63:0] old_fwd;
		logic [63:0] f;
		logic [63:0] r;
		logic [1:0]  c;
		logic [1:0]  dropped;
		logic        is_base;
		logic        prev_ok;
		o = '0;
		// zero length acts as one; nothing wider than the window fits
		k = (k_len == 0) ? 1 : k_len;
		if (k > cke_pkg::CELLS_MAX)
			k = cke_pkg::CELLS_MAX;
		mask = (64'd1 << (2 * k)) - 64'd1;
		top = 2 * (k - 1);
		if (req.seq_start)
			clear_window();
		ch = req.base_char;
		if (ch >= cke_pkg::CH_LOW_A && ch <= cke_pkg::CH_LOW_Z)
			ch = ch - cke_pkg::CASE_OFS;
		is_base = 1'b1;
		c = cke_pkg::BASE_A;
		case (ch)
			cke_pkg::CH_A: c = cke_pkg::BASE_A;
			cke_pkg::CH_T: c = cke_pkg::BASE_T;
			cke_pkg::CH_C: c = cke_pkg::BASE_C;
			cke_pkg::CH_G: c = cke_pkg::BASE_G;
			default: is_base = 1'b0;
		endcase
		if (!is_base) begin
			// N restarts silently only while skipping is on
			o.bad_char = !(ch == cke_pkg::CH_N && skip_on);
			clear_window();
			if (o.bad_char)
				n_bad++;
			return o;
		end
		old_fwd = {2'b00, fwd_win} & mask;
		prev_ok = fill_cnt >= k;
		f = ((old_fwd << 2) | 64'(c)) & mask;
		r = ((({2'b00, rev_win} & mask) >> 2) |
			(64'(c ^ cke_pkg::COMP_MASK) << top)) & mask;
		fwd_win = f[cke_pkg::CODE_W-1:0];
		rev_win = r[cke_pkg::CODE_W-1:0];
		if (fill_cnt != cke_pkg::FILL_SAT)
			fill_cnt++;
		if (fill_cnt >= k) begin
			o.kmer_valid = 1'b1;
			o.fwd_code = f[cke_pkg::CODE_W-1:0];
			o.rev_code = r[cke_pkg::CODE_W-1:0];
			o.canonical_code = (f < r) ? f[cke_pkg::CODE_W-1:0] : r[cke_pkg::CODE_W-1:0];
			n_kmers++;
			if (prev_ok) begin
				dropped = 2'(old_fwd >> top);
				o.edge_valid = 1'b1;
				o.edge_from_fwd = old_fwd[cke_pkg::CODE_W-1:0];
				o.edge_fwd_hot = 4'b0001 << c;
				o.edge_rev_hot = 4'b0001 << (dropped ^ cke_pkg::COMP_MASK);
				n_edges++;
			end
		end
		return o;
	endfunction

	// --------------------------------------------------------------------
	// Checking
	// --------------------------------------------------------------------
	task automatic cmp_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: field %s differs, expected %h, got %h",
					n_results, name, want, got);
		end
	endtask

	task automatic check_result(input cke_pkg::cke_out_t got);
		cke_pkg::cke_out_t want;
		n_results++;
		if (pending_kmers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with no request outstanding", n_results);
			return;
		end
		want = pending_kmers.pop_front();
		cmp_field("kmer_valid", want.kmer_valid, got.kmer_valid);
		cmp_field("fwd_code", want.fwd_code, got.fwd_code);
		cmp_field("rev_code", want.rev_code, got.rev_code);
		cmp_field("canonical_code", want.canonical_code, got.canonical_code);
		cmp_field("edge_valid", want.edge_valid, got.edge_valid);
		cmp_field("edge_from_fwd", want.edge_from_fwd, got.edge_from_fwd);
		cmp_field("edge_fwd_hot", want.edge_fwd_hot, got.edge_fwd_hot);
		cmp_field("edge_rev_hot", want.edge_rev_hot, got.edge_rev_hot);
		cmp_field("bad_char", want.bad_char, got.bad_char);
	endtask

	// Sample both channels and the register port at the rising edge.
	always @(posedge clk) begin : monitor
		bit moved;
		cke_pkg::cke_out_t pred;
		moved = 1'b0;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				check_result(result);
				moved = 1'b1;
			end
			if (item_valid && item_ready) begin
				pred = encode_base(req_item);
				pending_kmers.insert(pending_kmers.size(), pred);
				n_chars++;
				moved = 1'b1;
			end
			if (cfg_we) begin
				if (cfg_index == cke_pkg::REG_K_LEN)
					k_len = cfg_data[cke_pkg::K_W-1:0];
				else if (cfg_index == cke_pkg::REG_SKIP_N)
					skip_on = cfg_data[0];
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= HANG_LIMIT);
		$display("timeout: no request moved for %0d cycles", HANG_LIMIT);
		$display("canonical_kmer_stream_encoder: mismatch");
		$finish;
	end

	// Stall the result side in random bursts; none once calm.
	always @(negedge clk) begin : result_stall
		int left;
		logic nxt;
		if (left > 0) begin
			left--;
			nxt = 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 99) < stall_pct) begin
			left = $urandom_range(0, 3);
			nxt = 1'b0;
		end else begin
			nxt = 1'b1;
		end
		result_ready <= nxt;
	end

	// --------------------------------------------------------------------
	// Stimulus helpers; each is entered and left at a falling edge
	// --------------------------------------------------------------------
	task automatic send_req(input logic [7:0] ch, input logic start);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_item <= '{base_char: ch, seq_start: start};
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic start);
		int i;
		for (i = 0; i < s.len(); i++)
			send_req(s[i], start && i == 0);
	endtask

	// Drop valid and wait out every outstanding result plus the latency.
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_kmers.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cke_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= cke_pkg::CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == cke_pkg::REG_K_LEN)
			n_settings++;
	endtask

	function automatic logic [7:0] rand_base();
		logic [7:0] ch;
		case ($urandom_range(0, 3))
			0: ch = cke_pkg::CH_A;
			1: ch = cke_pkg::CH_T;
			2: ch = cke_pkg::CH_C;
			default: ch = cke_pkg::CH_G;
		endcase
		if ($urandom_range(0, 1))
			ch = ch + cke_pkg::CASE_OFS;
		return ch;
	endfunction

	// Mostly bases; noise_pct percent are N, any byte, or any upper-case letter.
	function automatic logic [7:0] rand_char(input int noise_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll >= noise_pct)
			return rand_base();
		case ($urandom_range(0, 2))
			0: return $urandom_range(0, 1) ? cke_pkg::CH_N
				: cke_pkg::CH_N + cke_pkg::CASE_OFS;
			1: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(0, 25)) + cke_pkg::CH_A;
		endcase
	endfunction

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------

	// Edge cases: zero length, case folding, N handling, bad bytes,
	// restart, and k changed with a live window.
	task automatic test_directed();
		write_reg(cke_pkg::REG_K_LEN, 0);
		send_text("AcGt", 1'b1);
		send_text("NAx", 1'b0);
		send_req(8'h00, 1'b0);
		send_req(8'hFF, 1'b1);
		send_req(cke_pkg::CH_N + cke_pkg::CASE_OFS, 1'b0);
		settle();
		write_reg(cke_pkg::REG_SKIP_N, 0);
		send_text("NG", 1'b0);
		settle();
		write_reg(cke_pkg::REG_K_LEN, 3);
		write_reg(cke_pkg::REG_SKIP_N, 1);
		send_text("ACGTA", 1'b1);
		send_text("CGTT", 1'b1);
		settle();
		// shrink, then grow, the window under a filled count
		write_reg(cke_pkg::REG_K_LEN, 2);
		send_text("GA", 1'b0);
		settle();
		write_reg(cke_pkg::REG_K_LEN, 4);
		send_req(cke_pkg::CH_T, 1'b0);
		settle();
	endtask

	// Longest window, run long enough to saturate the fill count.
	task automatic test_full_window();
		int i;
		write_reg(cke_pkg::REG_K_LEN, cke_pkg::CELLS_MAX);
		for (i = 0; i < 80; i++)
			send_req(rand_base(), i == 0);
		send_req(cke_pkg::CH_N, 1'b0);
		for (i = 0; i < 40; i++)
			send_req(rand_base(), 1'b0);
		settle();
	endtask

	// Random phases over several settings; one phase pauses mid-stream.
	task automatic test_random_phases();
		int p;
		int i;
		int k;
		int noise;
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: k = 1;
				1, 2: k = cke_pkg::CELLS_MAX;
				default: k = $urandom_range(1, cke_pkg::CELLS_MAX);
			endcase
			write_reg(cke_pkg::REG_K_LEN, k);
			write_reg(cke_pkg::REG_SKIP_N, (p == 2) ? 0 : $urandom_range(0, 1));
			gap_pct = (p == 4) ? 0 : $urandom_range(0, 40);
			stall_pct = (p == 5) ? 0 : $urandom_range(0, 40);
			// long windows need long clean runs to produce any k-mers
			noise = (k >= 20) ? 1 : 12;
			for (i = 0; i < PHASE_REQS; i++) begin
				if (p == 3 && i == PHASE_REQS / 2)
					settle();
				send_req(rand_char(noise), $urandom_range(0, 49) == 0);
			end
			settle();
		end
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_calm();
		int i;
		calm = 1'b1;
		write_reg(cke_pkg::REG_K_LEN, $urandom_range(2, 8));
		write_reg(cke_pkg::REG_SKIP_N, 1);
		for (i = 0; i < 150; i++)
			send_req(rand_char(8), $urandom_range(0, 49) == 0);
		settle();
	endtask

	initial begin : main
		fwd_win = '0;
		rev_win = '0;
		fill_cnt = '0;
		k_len = cke_pkg::K_W'(cke_pkg::CELLS_MAX);
		skip_on = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_full_window();
		test_random_phases();
		test_calm();

		// hold for the output register before the final tally
		repeat (4) @(negedge clk);
		if (pending_kmers.size() != 0) begin
			mismatches += pending_kmers.size();
			$display("%0d results never arrived", pending_kmers.size());
		end
		$display("sent %0d characters over %0d k settings: %0d k-mers, %0d edges,",
			n_chars, n_settings, n_kmers, n_edges);
		$display("%0d bad characters, %0d results checked, %0d field errors",
			n_bad, n_results, mismatches);
		if (mismatches == 0)
			$display("canonical_kmer_stream_encoder: match");
		else
			$display("canonical_kmer_stream_encoder: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cke_pkg.sv
rtl/cke_cell.sv
rtl/cke_ctrl.sv
rtl/canonical_kmer_stream_encoder.sv
test/tb.sv
